FILE: hdl/drbt_pkg.sv
`default_nettype none

package drbt_pkg;

	// Fixed field widths
	localparam int LAT_W     = 10;
	localparam int TIM_W     = 8;
	localparam int CNT_W     = 48;
	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 3;

	// Folded bank residue: up to eight byte residues of at most 63 each
	localparam int FOLD_W = 9;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIXED_LAT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_T_ACT     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_T_COL     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_T_PRE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_T_BUS     = 3'd5;

	// Configuration reset values
	localparam logic             RST_ROW_MODE  = 1'b1;
	localparam logic [LAT_W-1:0] RST_FIXED_LAT = 10'd100;
	localparam logic [TIM_W-1:0] RST_T_ACT     = 8'd45;
	localparam logic [TIM_W-1:0] RST_T_COL     = 8'd45;
	localparam logic [TIM_W-1:0] RST_T_PRE     = 8'd45;
	localparam logic [TIM_W-1:0] RST_T_BUS     = 8'd10;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Access classification
	typedef enum logic [1:0] {
		OUT_HIT      = 2'd0,
		OUT_EMPTY    = 2'd1,
		OUT_CONFLICT = 2'd2,
		OUT_FIXED    = 2'd3
	} outcome_t;

endpackage

`default_nettype wire

FILE: hdl/drbt_bank_fold.sv
`default_nettype none

// Bank select = line address modulo BANK_COUNT, computed in two halves.
// First half: each address byte goes through a residue table that already
// folds in its byte weight, and the residues are summed (narrow result).
// Second half: the sum is reduced to a bank number with two table lookups.
module drbt_bank_fold #(
	parameter int BANK_COUNT   = 16,
	parameter int ADDRESS_BITS = 32
) (
	input  wire logic [ADDRESS_BITS-1:0]         addr,
	output logic      [drbt_pkg::FOLD_W-1:0]     fold,
	input  wire logic [drbt_pkg::FOLD_W-1:0]     fold_in,
	output logic      [$clog2(BANK_COUNT)-1:0]   bank
);
	import drbt_pkg::*;

	localparam int BW    = $clog2(BANK_COUNT);
	localparam int NCH   = (ADDRESS_BITS + 7) / 8;
	localparam int PAD_W = NCH * 8;
	localparam int K256  = 256 % BANK_COUNT;

	logic [PAD_W-1:0] addr_pad;
	logic [BW-1:0]    res_tab [NCH][256];
	logic [6:0]       part_sum;

	assign addr_pad = PAD_W'(addr);

	// Constant tables: (byte * 2^(8j)) mod BANK_COUNT
	for (genvar j = 0; j < NCH; j++) begin : g_chunk
		for (genvar c = 0; c < 256; c++) begin : g_ent
			localparam longint unsigned WGT = (64'd1 << (8 * j)) % BANK_COUNT;
			localparam longint unsigned VAL = ((c % BANK_COUNT) * WGT) % BANK_COUNT;
			assign res_tab[j][c] = BW'(VAL);
		end
	end

	// Sum of byte residues, congruent to the address
	always_comb begin
		fold = '0;
		for (int j = 0; j < NCH; j++) begin
			fold = fold + FOLD_W'(res_tab[j][addr_pad[8*j +: 8]]);
		end
	end

	// Final reduction: fold_in < 512, low byte plus weighted top bit, then one more lookup
	assign part_sum = 7'(res_tab[0][fold_in[7:0]]) + (fold_in[8] ? 7'(K256) : 7'd0);
	assign bank     = res_tab[0][{1'b0, part_sum}];

endmodule

`default_nettype wire

FILE: hdl/dram_row_buffer_timing_core.sv
`default_nettype none

// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+------------------------------------------
// request   | in        | in_valid/in_ready  | req_type, line_address
// response  | out       | out_valid/out_ready| latency, outcome, read/write counts+totals
// config    | in        | cfg_we (no wait)   | cfg_index, cfg_data
//
// Three register stages: input capture with byte-residue fold, bank select,
// then bank table read-modify-write plus counter update into the output
// registers. out_valid rises when an accepted transaction has moved through
// stages 1 and 2 into the output register. One transaction per cycle
// sustained while out_ready is high; the bank table read-modify-write in the
// last stage keeps pace. Each stage advances when empty or when the next one
// advances, so a stalled output only holds back stages that are full. Reset
// clears open-row valid bits, counters and stage valids; config returns to defaults.
module dram_row_buffer_timing_core #(
	parameter int BANK_COUNT   = 16,
	parameter int ADDRESS_BITS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// request
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              req_type,
	input  wire logic [ADDRESS_BITS-1:0]           line_address,
	// response
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic      [drbt_pkg::LAT_W-1:0]        latency,
	output logic      [1:0]                        outcome,
	output logic      [drbt_pkg::CNT_W-1:0]        read_count,
	output logic      [drbt_pkg::CNT_W-1:0]        write_count,
	output logic      [drbt_pkg::CNT_W-1:0]        read_delay_total,
	output logic      [drbt_pkg::CNT_W-1:0]        write_delay_total,
	// configuration
	input  wire logic                              cfg_we,
	input  wire logic [drbt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [drbt_pkg::CFG_W-1:0]        cfg_data
);
	import drbt_pkg::*;

	localparam int BW = $clog2(BANK_COUNT);

	// Configuration registers
	logic             row_mode_q;
	logic [LAT_W-1:0] fixed_lat_q;
	logic [TIM_W-1:0] t_act_q;
	logic [TIM_W-1:0] t_col_q;
	logic [TIM_W-1:0] t_pre_q;
	logic [TIM_W-1:0] t_bus_q;

	// Pipeline
	logic                    vld_s1, vld_s2, out_vld_q;
	logic                    adv1, adv2, adv_out;
	logic                    fire_in, fire1, fire2;
	logic                    type_s1, type_s2;
	logic [ADDRESS_BITS-1:0] addr_s1, addr_s2;
	logic [FOLD_W-1:0]       fold_in_w, fold_s1;
	logic [BW-1:0]           bank_w, bank_s2;

	// Open-page table
	logic [BANK_COUNT-1:0]   bank_vld_q;
	logic [ADDRESS_BITS-1:0] bank_addr_q [BANK_COUNT];

	// Last stage results
	logic                    open_vld;
	logic [ADDRESS_BITS-1:0] open_addr;
	logic [LAT_W-1:0]        lat_base, lat_nxt;
	outcome_t                outc_nxt;
	logic [LAT_W-1:0]        lat_q;
	outcome_t                outc_q;

	// Counters (double as response registers)
	logic [CNT_W-1:0] rd_cnt_q, wr_cnt_q, rd_sum_q, wr_sum_q;
	logic [CNT_W:0]   rd_sum_add, wr_sum_add;

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_mode_q  <= RST_ROW_MODE;
			fixed_lat_q <= RST_FIXED_LAT;
			t_act_q     <= RST_T_ACT;
			t_col_q     <= RST_T_COL;
			t_pre_q     <= RST_T_PRE;
			t_bus_q     <= RST_T_BUS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROW_MODE:  row_mode_q  <= cfg_data[0];
				CFG_FIXED_LAT: fixed_lat_q <= cfg_data[LAT_W-1:0];
				CFG_T_ACT:     t_act_q     <= cfg_data[TIM_W-1:0];
				CFG_T_COL:     t_col_q     <= cfg_data[TIM_W-1:0];
				CFG_T_PRE:     t_pre_q     <= cfg_data[TIM_W-1:0];
				CFG_T_BUS:     t_bus_q     <= cfg_data[TIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage flow control
	assign adv_out  = !out_vld_q || out_ready;
	assign adv2     = !vld_s2 || adv_out;
	assign adv1     = !vld_s1 || adv2;
	assign in_ready = adv1;
	assign fire_in  = in_valid && adv1;
	assign fire1    = vld_s1 && adv2;
	assign fire2    = vld_s2 && adv_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (adv1)    vld_s1    <= in_valid;
			if (adv2)    vld_s2    <= vld_s1;
			if (adv_out) out_vld_q <= vld_s2;
		end
	end

	// Bank select
	drbt_bank_fold #(
		.BANK_COUNT   (BANK_COUNT),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_bank_fold (
		.addr    (line_address),
		.fold    (fold_in_w),
		.fold_in (fold_s1),
		.bank    (bank_w)
	);

	// Stage payloads
	always_ff @(posedge clk) begin
		if (fire_in) begin
			type_s1 <= req_type;
			addr_s1 <= line_address;
			fold_s1 <= fold_in_w;
		end
		if (fire1) begin
			type_s2 <= type_s1;
			addr_s2 <= addr_s1;
			bank_s2 <= bank_w;
		end
	end

	// Classify against the open row; same bank and same address means same row
	assign open_vld  = bank_vld_q[bank_s2];
	assign open_addr = bank_addr_q[bank_s2];
	assign lat_base  = LAT_W'(t_col_q) + LAT_W'(t_bus_q);

	always_comb begin
		priority if (!row_mode_q) begin
			lat_nxt  = fixed_lat_q;
			outc_nxt = OUT_FIXED;
		end else if (open_vld && open_addr == addr_s2) begin
			lat_nxt  = lat_base;
			outc_nxt = OUT_HIT;
		end else if (!open_vld) begin
			lat_nxt  = lat_base + LAT_W'(t_act_q);
			outc_nxt = OUT_EMPTY;
		end else begin
			lat_nxt  = lat_base + LAT_W'(t_act_q) + LAT_W'(t_pre_q);
			outc_nxt = OUT_CONFLICT;
		end
	end

	// Open-page table update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_vld_q <= '0;
		end else if (fire2 && row_mode_q) begin
			bank_vld_q[bank_s2] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire2 && row_mode_q) begin
			bank_addr_q[bank_s2] <= addr_s2;
		end
	end

	// Saturating totals
	assign rd_sum_add = {1'b0, rd_sum_q} + (CNT_W+1)'(lat_nxt);
	assign wr_sum_add = {1'b0, wr_sum_q} + (CNT_W+1)'(lat_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
			wr_cnt_q <= '0;
			rd_sum_q <= '0;
			wr_sum_q <= '0;
		end else if (fire2) begin
			if (type_s2) begin
				if (wr_cnt_q != CNT_MAX) wr_cnt_q <= wr_cnt_q + CNT_W'(1);
				wr_sum_q <= wr_sum_add[CNT_W] ? CNT_MAX : wr_sum_add[CNT_W-1:0];
			end else begin
				if (rd_cnt_q != CNT_MAX) rd_cnt_q <= rd_cnt_q + CNT_W'(1);
				rd_sum_q <= rd_sum_add[CNT_W] ? CNT_MAX : rd_sum_add[CNT_W-1:0];
			end
		end
	end

	// Response registers
	always_ff @(posedge clk) begin
		if (fire2) begin
			lat_q  <= lat_nxt;
			outc_q <= outc_nxt;
		end
	end

	assign out_valid         = out_vld_q;
	assign latency           = lat_q;
	assign outcome           = outc_q;
	assign read_count        = rd_cnt_q;
	assign write_count       = wr_cnt_q;
	assign read_delay_total  = rd_sum_q;
	assign write_delay_total = wr_sum_q;

`ifndef SYNTH
	// Backpressure only when every stage holds a transaction
	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (vld_s1 && vld_s2 && out_vld_q))
		else $error("in_ready low with a free pipeline slot");

	// A write leaves the read counters alone
	a_write_keeps_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(fire2 && type_s2) |=> ($stable(rd_cnt_q) && $stable(rd_sum_q)))
		else $error("read counters changed on a write");

	// Delay totals never go backwards
	a_sum_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (rd_sum_q >= $past(rd_sum_q) && wr_sum_q >= $past(wr_sum_q)))
		else $error("delay total decreased");
`endif

endmodule

`default_nettype wire
